/* rtl/core/msf_pkg.sv */
package msf_pkg;

   // request actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_RUN   = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // result kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_BOX   = 1'b1;

   // configuration register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // one access to the pixel store
   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] wdata;
   } mem_cmd_type;

   // bounding box of the black pixels
   typedef struct packed {
      logic [7:0] left;
      logic [7:0] right;
      logic [7:0] top;
      logic [7:0] bottom;
   } box_type;

   // one result item
   typedef struct packed {
      logic       kind;
      logic [7:0] pixel;
      box_type    box;
   } result_type;

endpackage

/* rtl/core/msf_store.sv */
module msf_store
   import msf_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  mem_cmd_type mem_cmd,
   output logic [7:0]  rd_data
);

   localparam int EFF_W = (MAX_WIDTH > 256) ? 256 : MAX_WIDTH;
   localparam int EFF_H = (MAX_HEIGHT > 256) ? 256 : MAX_HEIGHT;
   localparam int CB    = $clog2(EFF_W);
   localparam int RB    = $clog2(EFF_H);
   localparam int DEPTH = 1 << (CB + RB);

   logic [7:0]         mem [DEPTH];
   logic [CB+RB-1:0]   addr;
   logic [7:0]         rd_data_ff;

   // row-major address from the low bits of column and row
   assign addr = {mem_cmd.row[RB-1:0], mem_cmd.col[CB-1:0]};

   // single port array, registered read
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[addr] <= mem_cmd.wdata;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/msf_seq.sv */
module msf_seq
   import msf_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_take,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_col,
   input  logic [7:0]  req_row,
   input  logic [7:0]  req_pixel,
   input  logic [8:0]  width_eff,
   input  logic [8:0]  height_eff,
   input  logic [7:0]  rd_data,
   output mem_cmd_type mem_cmd,
   output logic        busy,
   output logic        rsp_load,
   output result_type  rsp_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_PICK  = 3'd4;
   localparam logic [2:0] ST_FILL  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       pass_ff, pass_in;
   logic [7:0] line_ff, line_in;
   logic [7:0] pos_ff, pos_in;
   logic       vld_d_ff, vld_d_in;
   logic [7:0] pos_d_ff, pos_d_in;
   logic       found_ff, found_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] last_ff, last_in;
   logic       box_found_ff, box_found_in;
   box_type    box_ff, box_in;
   logic       inside_ff, inside_in;

   logic [8:0] line_cnt;
   logic [8:0] span_len;
   logic       last_pos;
   logic       last_line;
   logic       req_inside;
   logic       advance;

   // rows in the first pass, columns in the second
   assign line_cnt  = pass_ff ? width_eff : height_eff;
   assign span_len  = pass_ff ? height_eff : width_eff;
   assign last_pos  = ({1'b0, pos_ff} == (span_len - 9'd1));
   assign last_line = ({1'b0, line_ff} == (line_cnt - 9'd1));
   assign req_inside = (32'(req_col) < MAX_WIDTH) && (32'(req_row) < MAX_HEIGHT);
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      line_in      = line_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      box_found_in = box_found_ff;
      box_in       = box_ff;
      inside_in    = inside_ff;
      advance      = 1'b0;
      mem_cmd      = '0;
      rsp_load     = 1'b0;
      rsp_data     = '0;

      vld_d_in = (state_ff == ST_SCAN);
      pos_d_in = pos_ff;

      // span tracker on the registered store data
      if (vld_d_ff && (rd_data == 8'd0)) begin
         if (!found_ff) begin
            first_in = pos_d_ff;
         end
         last_in  = pos_d_ff;
         found_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_action)
                  ACT_WRITE: begin
                     mem_cmd.wr_en = req_inside;
                     mem_cmd.col   = req_col;
                     mem_cmd.row   = req_row;
                     mem_cmd.wdata = req_pixel;
                  end
                  ACT_READ: begin
                     mem_cmd.rd_en = req_inside;
                     mem_cmd.col   = req_col;
                     mem_cmd.row   = req_row;
                     inside_in     = req_inside;
                     state_in      = ST_READ;
                  end
                  ACT_RUN: begin
                     box_in       = '0;
                     box_found_in = 1'b0;
                     pass_in      = 1'b0;
                     line_in      = 8'd0;
                     pos_in       = 8'd0;
                     found_in     = 1'b0;
                     if ((width_eff == 9'd0) || (height_eff == 9'd0)) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load       = 1'b1;
            rsp_data.kind  = KIND_PIXEL;
            rsp_data.pixel = inside_ff ? rd_data : 8'd0;
            state_in       = ST_IDLE;
         end
         ST_SCAN: begin
            mem_cmd.rd_en = 1'b1;
            mem_cmd.col   = pass_ff ? line_ff : pos_ff;
            mem_cmd.row   = pass_ff ? pos_ff : line_ff;
            pos_in        = pos_ff + 8'd1;
            if (last_pos) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (found_ff) begin
               // row spans give the whole box, fill keeps it unchanged
               if (!pass_ff) begin
                  if (!box_found_ff) begin
                     box_in.left   = first_ff;
                     box_in.right  = last_ff;
                     box_in.top    = line_ff;
                     box_in.bottom = line_ff;
                     box_found_in  = 1'b1;
                  end else begin
                     box_in.left   = (first_ff < box_ff.left) ? first_ff : box_ff.left;
                     box_in.right  = (last_ff > box_ff.right) ? last_ff : box_ff.right;
                     box_in.bottom = line_ff;
                  end
               end
               pos_in   = first_ff;
               state_in = ST_FILL;
            end else begin
               advance = 1'b1;
            end
         end
         ST_FILL: begin
            mem_cmd.wr_en = 1'b1;
            mem_cmd.col   = pass_ff ? line_ff : pos_ff;
            mem_cmd.row   = pass_ff ? pos_ff : line_ff;
            mem_cmd.wdata = 8'd0;
            pos_in        = pos_ff + 8'd1;
            if (pos_ff == last_ff) begin
               advance = 1'b1;
            end
         end
         ST_DONE: begin
            rsp_load      = 1'b1;
            rsp_data.kind = KIND_BOX;
            rsp_data.box  = box_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next line, next pass or finish
      if (advance) begin
         found_in = 1'b0;
         pos_in   = 8'd0;
         if (last_line) begin
            line_in = 8'd0;
            if (!pass_ff) begin
               pass_in  = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end else begin
            line_in  = line_ff + 8'd1;
            state_in = ST_SCAN;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_d_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_d_ff <= vld_d_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pass_ff      <= pass_in;
      line_ff      <= line_in;
      pos_ff       <= pos_in;
      pos_d_ff     <= pos_d_in;
      found_ff     <= found_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      box_found_ff <= box_found_in;
      box_ff       <= box_in;
      inside_ff    <= inside_in;
   end

endmodule

/* rtl/core/mask_span_fill_bbox.sv */
// mask span fill and bounding box
//
// The request channel (req_valid / req_stall) carries one action per request:
// write pixel, run fill, or read pixel. A write gives no result. A read gives a
// pixel result from the registered store read by way of the output register. A run fills
// every row, then every column, of the active region between its first and last
// black pixel, and returns the box of the black pixels (all zero when empty).
// A run over a W x H region is bound by the single store port, which serves one
// read or one write a cycle. req_stall is high while a read or run is in progress
// and while a finished result waits under rsp_stall.
// Results sit in one output register: rsp_valid stays high and the payload holds
// until the receiver drops rsp_stall. Configuration (csr_*) sets the active width
// and height; the user must see that it is written only while the block is idle,
// which the block itself does not enforce. csr_ready is always high. Reset clears
// the sequencer and output valid and sets both sizes to 256; the pixel store is
// not cleared and a pixel must be written before it is used.
module mask_span_fill_bbox
   import msf_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_col_index,
   input  logic [7:0] req_row_index,
   input  logic [7:0] req_pixel_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_pixel_out,
   output logic [7:0] rsp_box_left,
   output logic [7:0] rsp_box_right,
   output logic [7:0] rsp_box_top,
   output logic [7:0] rsp_box_bottom,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [8:0] csr_wdata
);

   localparam int LIM_W = (MAX_WIDTH > 256) ? 256 : MAX_WIDTH;
   localparam int LIM_H = (MAX_HEIGHT > 256) ? 256 : MAX_HEIGHT;

   logic [8:0]  image_width_ff, image_width_in;
   logic [8:0]  image_height_ff, image_height_in;
   logic [8:0]  width_eff;
   logic [8:0]  height_eff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  result_ff;
   logic        req_take;
   logic        busy;
   logic        rsp_load;
   result_type  rsp_data;
   mem_cmd_type mem_cmd;
   logic [7:0]  rd_data;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WIDTH:  image_width_in  = csr_wdata;
            CSR_HEIGHT: image_height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // active region limited by the store size
   assign width_eff  = (image_width_ff > 9'(LIM_W)) ? 9'(LIM_W) : image_width_ff;
   assign height_eff = (image_height_ff > 9'(LIM_H)) ? 9'(LIM_H) : image_height_ff;

   // request handshake
   assign req_stall = busy || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   msf_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_take   (req_take),
      .req_action (req_action),
      .req_col    (req_col_index),
      .req_row    (req_row_index),
      .req_pixel  (req_pixel_in),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .rd_data    (rd_data),
      .mem_cmd    (mem_cmd),
      .busy       (busy),
      .rsp_load   (rsp_load),
      .rsp_data   (rsp_data)
   );

   msf_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_store (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 9'd256;
         image_height_ff <= 9'd256;
         rsp_valid_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         result_ff <= rsp_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = result_ff.kind;
   assign rsp_pixel_out   = result_ff.pixel;
   assign rsp_box_left    = result_ff.box.left;
   assign rsp_box_right   = result_ff.box.right;
   assign rsp_box_top     = result_ff.box.top;
   assign rsp_box_bottom  = result_ff.box.bottom;

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending result");

   // a read request gives a pixel result after the store read and the output register
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_action == ACT_READ)) |-> ##2
         (rsp_valid_ff && (result_ff.kind == KIND_PIXEL)))
      else $error("read result missing");

   // a box result is ordered
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (result_ff.kind == KIND_BOX)) |->
         ((result_ff.box.left <= result_ff.box.right) &&
          (result_ff.box.top <= result_ff.box.bottom)))
      else $error("bounding box out of order");

endmodule

/* tb/tb_mask_span_fill_bbox.sv */
`timescale 1ns / 100ps

module tb_mask_span_fill_bbox;
   import msf_pkg::*;

   // action code the block ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // random part stops once this many useful requests have gone in
   localparam int ITEM_TARGET = 1700;
   // watchdog limit on simulated cycles
   localparam int CYCLE_LIMIT = 1_000_000;
   // quiet cycles before a size register write
   localparam int SETTLE_CYCLES = 8;

   logic       clock;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [1:0] req_action      = ACT_WRITE;
   logic [7:0] req_col_index   = 8'd0;
   logic [7:0] req_row_index   = 8'd0;
   logic [7:0] req_pixel_in    = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic       rsp_result_kind;
   logic [7:0] rsp_pixel_out;
   logic [7:0] rsp_box_left;
   logic [7:0] rsp_box_right;
   logic [7:0] rsp_box_top;
   logic [7:0] rsp_box_bottom;
   logic       csr_valid       = 1'b0;
   logic       csr_ready;
   logic       csr_index       = CSR_WIDTH;
   logic [8:0] csr_wdata       = 9'd0;

   // predicted mask and which pixels have been written since reset
   logic [7:0] mask_img [256][256];
   bit         written  [256][256];
   logic [8:0] cfg_width  = 9'd256;
   logic [8:0] cfg_height = 9'd256;
   int         last_wr_col = 0;
   int         last_wr_row = 0;

   result_type pending_results [$];
   result_type want;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int items_sent    = 0;
   int err_count     = 0;
   int cycle_count   = 0;

   mask_span_fill_bbox dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_col_index   (req_col_index),
      .req_row_index   (req_row_index),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_box_left    (rsp_box_left),
      .rsp_box_right   (rsp_box_right),
      .rsp_box_top     (rsp_box_top),
      .rsp_box_bottom  (rsp_box_bottom),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_mask_span_fill_bbox: errors");
         $finish;
      end
   end

   // region size actually used by the fill
   function automatic int clip_size(logic [8:0] v);
      return (v > 9'd256) ? 256 : int'(v);
   endfunction

   // row spans, then column spans, then box of the black pixels
   function automatic box_type fill_and_box(int w, int h);
      int      first;
      int      last;
      bit      found;
      box_type bb;
      bb = '0;
      found = 1'b0;
      for (int r = 0; r < h; r++) begin
         first = -1;
         last = -1;
         for (int c = 0; c < w; c++) begin
            if (mask_img[r][c] == 8'd0) begin
               if (first < 0) first = c;
               last = c;
            end
         end
         if (first >= 0)
            for (int c = first; c <= last; c++) mask_img[r][c] = 8'd0;
      end
      for (int c = 0; c < w; c++) begin
         first = -1;
         last = -1;
         for (int r = 0; r < h; r++) begin
            if (mask_img[r][c] == 8'd0) begin
               if (first < 0) first = r;
               last = r;
            end
         end
         if (first >= 0)
            for (int r = first; r <= last; r++) mask_img[r][c] = 8'd0;
      end
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            if (mask_img[r][c] != 8'd0) continue;
            if (!found) begin
               bb.left   = 8'(c);
               bb.right  = 8'(c);
               bb.top    = 8'(r);
               bb.bottom = 8'(r);
               found = 1'b1;
            end else begin
               if (c < bb.left) bb.left = 8'(c);
               if (c > bb.right) bb.right = 8'(c);
               bb.bottom = 8'(r);
            end
         end
      end
      return bb;
   endfunction

   function automatic logic [7:0] pick_pixel(int black_pct);
      if ($urandom_range(99) < black_pct) return 8'd0;
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic set_idle_mode(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 53; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 53; end
         default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
   endtask

   // one request through the valid/stall handshake, then predict it
   task automatic send_request(logic [1:0] action, logic [7:0] col, logic [7:0] row,
                               logic [7:0] pix);
      result_type due;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= action;
      req_col_index <= col;
      req_row_index <= row;
      req_pixel_in  <= pix;
      do @(posedge clock); while (req_stall);
      due = '0;
      case (action)
         ACT_WRITE: begin
            mask_img[row][col] = pix;
            written[row][col] = 1'b1;
            last_wr_col = col;
            last_wr_row = row;
         end
         ACT_RUN: begin
            due.kind = KIND_BOX;
            due.box = fill_and_box(clip_size(cfg_width), clip_size(cfg_height));
            pending_results.push_back(due);
         end
         ACT_READ: begin
            due.kind = KIND_PIXEL;
            due.pixel = mask_img[row][col];
            pending_results.push_back(due);
         end
         default: ;
      endcase
      if (action != ACT_UNUSED) items_sent++;
   endtask

   // size register write, only once the block has gone quiet
   task automatic set_region_reg(logic idx, logic [8:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_WIDTH) cfg_width = value;
      else cfg_height = value;
   endtask

   // read of a pixel known to be written
   task automatic send_read(int ew, int eh);
      int col;
      int row;
      col = $urandom_range(0, 255);
      row = $urandom_range(0, 255);
      if (!written[row][col]) begin
         if ($urandom_range(1)) row = 0;
         else col = 0;
      end
      if (!written[row][col]) begin
         if (ew > 0 && eh > 0) begin
            col = $urandom_range(0, ew - 1);
            row = $urandom_range(0, eh - 1);
         end else begin
            col = last_wr_col;
            row = last_wr_row;
         end
      end
      send_request(ACT_READ, 8'(col), 8'(row), 8'($urandom));
   endtask

   // every pixel of the region written before any fill touches it
   task automatic load_region(int black_pct);
      int ew;
      int eh;
      ew = clip_size(cfg_width);
      eh = clip_size(cfg_height);
      for (int r = 0; r < eh; r++)
         for (int c = 0; c < ew; c++)
            send_request(ACT_WRITE, 8'(c), 8'(r), pick_pixel(black_pct));
   endtask

   // a few edits, noise and reads around one fill
   task automatic run_round(int black_pct);
      int ew;
      int eh;
      ew = clip_size(cfg_width);
      eh = clip_size(cfg_height);
      repeat ($urandom_range(0, 10)) begin
         if (ew > 0 && eh > 0 && $urandom_range(3) != 0)
            send_request(ACT_WRITE, 8'($urandom_range(0, ew - 1)),
                         8'($urandom_range(0, eh - 1)), pick_pixel(black_pct));
         else
            send_request(ACT_WRITE, 8'($urandom), 8'($urandom), pick_pixel(black_pct));
      end
      if ($urandom_range(4) == 0)
         send_request(ACT_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
      repeat ($urandom_range(0, 3)) send_read(ew, eh);
      send_request(ACT_RUN, 8'($urandom), 8'($urandom), 8'($urandom));
      repeat ($urandom_range(1, 5)) send_read(ew, eh);
   endtask

   // small hand-built masks: empty, single pixel, diagonal, far corner, ignored action
   task automatic test_directed_cases();
      set_idle_mode(0);
      set_region_reg(CSR_WIDTH, 9'd3);
      set_region_reg(CSR_HEIGHT, 9'd3);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            send_request(ACT_WRITE, 8'(c), 8'(r),
                         (r == 2 && c == 2) ? 8'hFF : 8'(1 + r * 3 + c));
      send_request(ACT_RUN, 8'd0, 8'd0, 8'd0);
      send_request(ACT_WRITE, 8'd1, 8'd1, 8'd0);
      send_request(ACT_RUN, 8'hFF, 8'hFF, 8'hFF);
      send_request(ACT_WRITE, 8'd2, 8'd0, 8'd0);
      send_request(ACT_WRITE, 8'd0, 8'd2, 8'd0);
      send_request(ACT_RUN, 8'd0, 8'd0, 8'd0);
      send_request(ACT_READ, 8'd0, 8'd0, 8'd0);
      send_request(ACT_WRITE, 8'hFF, 8'hFF, 8'd0);
      send_request(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      send_request(ACT_READ, 8'hFF, 8'hFF, 8'hFF);
      send_request(ACT_WRITE, 8'hFF, 8'd0, 8'hFF);
      send_request(ACT_READ, 8'hFF, 8'd0, 8'd0);
      send_request(ACT_READ, 8'd2, 8'd2, 8'd0);
   endtask

   // zero width or zero height: fill does nothing, box all zero
   task automatic test_empty_region();
      set_idle_mode(2);
      set_region_reg(CSR_WIDTH, 9'd0);
      set_region_reg(CSR_HEIGHT, 9'd5);
      repeat (2) run_round(30);
      set_region_reg(CSR_WIDTH, 9'd4);
      set_region_reg(CSR_HEIGHT, 9'd0);
      repeat (2) run_round(30);
   endtask

   // one full-width row, then an oversized width clipped to the store
   task automatic test_full_width_row();
      set_idle_mode(3);
      set_region_reg(CSR_WIDTH, 9'd256);
      set_region_reg(CSR_HEIGHT, 9'd1);
      load_region(4);
      repeat (2) run_round(4);
      set_region_reg(CSR_WIDTH, 9'd511);
      repeat (2) run_round(10);
   endtask

   // one full-height column, oversized height first
   task automatic test_full_height_column();
      set_idle_mode(1);
      set_region_reg(CSR_WIDTH, 9'd1);
      set_region_reg(CSR_HEIGHT, 9'd511);
      load_region(4);
      repeat (2) run_round(4);
      set_region_reg(CSR_HEIGHT, 9'd256);
      repeat (2) run_round(10);
   endtask

   // random small regions, densities and idling, cycled until enough requests
   task automatic test_random_masks();
      int phase;
      int span;
      int black_pct;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         set_idle_mode(phase % 4);
         span = ($urandom_range(4) == 0) ? 24 : 8;
         set_region_reg(CSR_WIDTH, 9'($urandom_range(1, span)));
         set_region_reg(CSR_HEIGHT, 9'($urandom_range(1, span)));
         case ($urandom_range(5))
            0: black_pct = 0;
            1: black_pct = 3;
            2: black_pct = 12;
            3: black_pct = 30;
            4: black_pct = 70;
            default: black_pct = 100;
         endcase
         load_region(black_pct);
         repeat (3) run_round(black_pct);
         phase++;
      end
   endtask

   task automatic check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         err_count++;
      end
   endtask

   // result checking and receiver stalls
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding, kind %0d", rsp_result_kind);
            err_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", want.kind, rsp_result_kind);
            check_field("pixel_out", want.pixel, rsp_pixel_out);
            check_field("box_left", want.box.left, rsp_box_left);
            check_field("box_right", want.box.right, rsp_box_right);
            check_field("box_top", want.box.top, rsp_box_top);
            check_field("box_bottom", want.box.bottom, rsp_box_bottom);
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_empty_region();
      test_full_width_row();
      test_full_height_column();
      test_random_masks();
      // drain
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("tb_mask_span_fill_bbox: clean");
      else
         $display("tb_mask_span_fill_bbox: errors");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/msf_pkg.sv
rtl/core/msf_store.sv
rtl/core/msf_seq.sv
rtl/core/mask_span_fill_bbox.sv
tb/tb_mask_span_fill_bbox.sv
